/* src/handlebar_light_controller_top_macros.svh */
// Assertion helpers for the handlebar light controller.
// Both macros sample on clk and are disabled while rst is high.
`ifndef HANDLEBAR_LIGHT_CONTROLLER_TOP_MACROS_SVH
`define HANDLEBAR_LIGHT_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH

// Consequence must hold in the same cycle as the antecedent
`define HLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hlc assertion failed");

// Consequence must hold in the cycle after the antecedent
`define HLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hlc assertion failed");

`else

`define HLC_ASSERT_SAME(lbl, ante, cons)
`define HLC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/hlc_pkg.sv */
`default_nettype none

package hlc_pkg;

  // Width of the debounce and kill hold-off timers
  localparam int TimerWidth = 16;
  localparam logic [TimerWidth-1:0] TimerMax = '1;

  // Configuration register indexes
  localparam logic [1:0] RegDebounce    = 2'd0;
  localparam logic [1:0] RegBlinkPeriod = 2'd1;
  localparam logic [1:0] RegKillHold    = 2'd2;

  // Register reset values
  localparam logic [15:0] DebounceReset    = 16'd50;
  localparam logic [15:0] BlinkPeriodReset = 16'd1000;
  localparam logic [15:0] KillHoldReset    = 16'd5000;

  // Gesture event codes
  localparam logic [3:0] EvNone       = 4'd0;
  localparam logic [3:0] EvLeftPush   = 4'd1;
  localparam logic [3:0] EvLeftHold   = 4'd2;
  localparam logic [3:0] EvRightPush  = 4'd3;
  localparam logic [3:0] EvRightHold  = 4'd4;
  localparam logic [3:0] EvBothPush   = 4'd5;
  localparam logic [3:0] EvBothHold   = 4'd6;
  localparam logic [3:0] EvPowerOn    = 4'd7;
  localparam logic [3:0] EvPowerOff   = 4'd8;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] blink_period_ms;
    logic [15:0] kill_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic       horn_switch;
    logic       brake_switch;
    logic       config_switch;
    logic       right_switch;
    logic       left_switch;
    logic [3:0] func;
  } in_item_t;

  typedef struct packed {
    logic [1:0] push_code;
    logic       horn_drive;
    logic       right_indicator;
    logic       left_indicator;
    logic       brake_lamp;
    logic       high_beam_lamp;
    logic       low_beam_lamp;
    logic       position_lamp;
    logic       engine_enable;
  } result_t;

endpackage

`default_nettype wire

/* src/handlebar_light_controller_top.sv */
// Channel   Direction  Payload (from bit 0 up)
// s_axis    in         func[3:0], left, right, config, brake, horn switches
// m_axis    out        engine, position, low, high, brake, left ind, right ind,
//                      horn, push_code[1:0]
// cfg       in         cfg_we, cfg_index (0 debounce, 1 blink period, 2 kill hold)
//
// One item per clock sustained while m_axis_tready stays high; an accepted item
// passes the input register, then the event logic into the result register,
// and m_axis_tvalid rises once the result register is loaded.
// The input register refills while a result waits, so one stalled result
// still leaves room for one more item before s_axis_tready drops.
// rst is synchronous; it clears all flags, timers and valid bits and
// restores the register defaults (50, 1000, 5000).
`default_nettype none

`include "handlebar_light_controller_top_macros.svh"

module handlebar_light_controller_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // func[3:0], left, right, config, brake, horn
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // engine, position, low, high, brake,
                                          // left ind, right ind, horn, push_code[1:0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  hlc_pkg::cfg_t     cfg;
  logic              in_valid;
  hlc_pkg::in_item_t in_item;
  logic              move;
  hlc_pkg::result_t  core_result;
  hlc_pkg::result_t  out_result;

  // Move an item forward when the result register is free or draining
  assign move          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= hlc_pkg::DebounceReset;
      cfg.blink_period_ms <= hlc_pkg::BlinkPeriodReset;
      cfg.kill_hold_ms    <= hlc_pkg::KillHoldReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hlc_pkg::RegDebounce:    cfg.debounce_ms     <= cfg_data;
        hlc_pkg::RegBlinkPeriod: cfg.blink_period_ms <= cfg_data;
        hlc_pkg::RegKillHold:    cfg.kill_hold_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture one input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_item <= hlc_pkg::in_item_t'(s_axis_tdata[8:0]);
  end

  hlc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (move),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_result <= core_result;
  end

  assign m_axis_tdata = {6'd0, out_result};

  `HLC_ASSERT_SAME(a_no_overrun, in_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `HLC_ASSERT_NEXT(a_move_fills_output, move, m_axis_tvalid)
  `HLC_ASSERT_SAME(a_one_indicator, m_axis_tvalid, !(m_axis_tdata[5] && m_axis_tdata[6]))
  `HLC_ASSERT_SAME(a_beam_exclusive, m_axis_tvalid, !(m_axis_tdata[2] && m_axis_tdata[3]))

endmodule

`default_nettype wire

/* src/hlc_core.sv */
`default_nettype none

module hlc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire hlc_pkg::in_item_t item,
  input  wire hlc_pkg::cfg_t    cfg,
  output hlc_pkg::result_t      result
);

  logic                             system_on, system_on_next;
  logic                             main_on, main_on_next;
  logic                             high_on, high_on_next;
  logic                             position_on, position_on_next;
  logic                             left_turn, left_turn_next;
  logic                             right_turn, right_turn_next;
  logic [15:0]                      blink_phase, blink_phase_next;
  logic [hlc_pkg::TimerWidth-1:0]   kill_timer, kill_timer_next;
  logic [hlc_pkg::TimerWidth-1:0]   stable_count, stable_count_next;
  logic [1:0]                       accepted_push, accepted_push_next;
  logic [1:0]                       candidate_push, candidate_push_next;

  logic [16:0]                      phase_inc;
  logic [1:0]                       raw;
  logic [hlc_pkg::TimerWidth-1:0]   kill_load;
  logic [15:0]                      half_period;

  assign phase_inc   = {1'b0, blink_phase} + 17'd1;
  assign raw         = {item.right_switch, item.left_switch};
  assign half_period = cfg.blink_period_ms >> 1;
  assign kill_load   = (32'(cfg.kill_hold_ms) < 32'(hlc_pkg::TimerMax))
                     ? hlc_pkg::TimerWidth'(cfg.kill_hold_ms) : hlc_pkg::TimerMax;

  // Advance timers, debounce the push code, then apply the event
  always_comb begin
    stable_count_next   = (stable_count != hlc_pkg::TimerMax)
                        ? stable_count + hlc_pkg::TimerWidth'(1) : stable_count;
    kill_timer_next     = (kill_timer != '0)
                        ? kill_timer - hlc_pkg::TimerWidth'(1) : kill_timer;
    blink_phase_next    = (phase_inc >= {1'b0, cfg.blink_period_ms})
                        ? 16'd0 : phase_inc[15:0];
    candidate_push_next = candidate_push;
    accepted_push_next  = accepted_push;
    system_on_next      = system_on;
    main_on_next        = main_on;
    high_on_next        = high_on;
    position_on_next    = position_on;
    left_turn_next      = left_turn;
    right_turn_next     = right_turn;

    if (raw != accepted_push) begin
      if (candidate_push != raw) stable_count_next = '0;
      candidate_push_next = raw;
      if (32'(stable_count_next) > 32'(cfg.debounce_ms)) accepted_push_next = raw;
    end

    unique case (item.func)
      hlc_pkg::EvLeftPush: begin
        if (system_on && main_on) begin
          if (item.config_switch) begin
            if (left_turn) begin
              left_turn_next = 1'b0;
            end else if (!right_turn) begin
              left_turn_next   = 1'b1;
              blink_phase_next = 16'd0;
            end
          end else begin
            high_on_next = !high_on;
          end
        end
      end
      hlc_pkg::EvLeftHold: begin
        if (system_on) begin
          if (item.config_switch) begin
            if (main_on) high_on_next = !high_on;
          end else if (left_turn) begin
            left_turn_next = 1'b0;
          end else if (!right_turn) begin
            left_turn_next   = 1'b1;
            blink_phase_next = 16'd0;
          end
        end else begin
          position_on_next = !position_on;
        end
      end
      hlc_pkg::EvRightPush: begin
        if (system_on && main_on) begin
          if (item.config_switch) begin
            if (right_turn) begin
              right_turn_next = 1'b0;
            end else if (!left_turn) begin
              right_turn_next  = 1'b1;
              blink_phase_next = 16'd0;
            end
          end else begin
            // Main lights are on here, so the toggle switches them off
            main_on_next    = 1'b0;
            high_on_next    = 1'b0;
            left_turn_next  = 1'b0;
            right_turn_next = 1'b0;
          end
        end
      end
      hlc_pkg::EvRightHold: begin
        if (system_on) begin
          if (item.config_switch) begin
            if (!main_on) begin
              main_on_next = 1'b1;
            end else begin
              main_on_next    = 1'b0;
              high_on_next    = 1'b0;
              left_turn_next  = 1'b0;
              right_turn_next = 1'b0;
            end
          end else if (right_turn) begin
            right_turn_next = 1'b0;
          end else if (!left_turn) begin
            right_turn_next  = 1'b1;
            blink_phase_next = 16'd0;
          end
        end
      end
      hlc_pkg::EvBothHold: begin
        if (system_on) kill_timer_next = kill_load;
      end
      hlc_pkg::EvPowerOn: begin
        if (!system_on) begin
          system_on_next   = 1'b1;
          main_on_next     = 1'b1;
          high_on_next     = 1'b0;
          position_on_next = 1'b0;
          left_turn_next   = 1'b0;
          right_turn_next  = 1'b0;
        end
      end
      hlc_pkg::EvPowerOff: begin
        if (system_on) begin
          system_on_next   = 1'b0;
          main_on_next     = 1'b0;
          high_on_next     = 1'b0;
          position_on_next = 1'b0;
          left_turn_next   = 1'b0;
          right_turn_next  = 1'b0;
        end
      end
      default: begin
        // no event, both push and undefined codes change nothing
      end
    endcase
  end

  // Form the lamp and drive outputs from the updated state
  always_comb begin
    result.engine_enable   = system_on_next && (kill_timer_next == '0);
    result.position_lamp   = position_on_next || main_on_next;
    result.low_beam_lamp   = main_on_next && !high_on_next;
    result.high_beam_lamp  = main_on_next && high_on_next;
    result.brake_lamp      = item.brake_switch && system_on_next;
    result.left_indicator  = left_turn_next && (blink_phase_next < half_period);
    result.right_indicator = right_turn_next && (blink_phase_next < half_period);
    result.horn_drive      = item.horn_switch;
    result.push_code       = accepted_push_next;
  end

  // Commit state when an item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      system_on      <= 1'b0;
      main_on        <= 1'b0;
      high_on        <= 1'b0;
      position_on    <= 1'b0;
      left_turn      <= 1'b0;
      right_turn     <= 1'b0;
      blink_phase    <= 16'd0;
      kill_timer     <= '0;
      stable_count   <= '0;
      accepted_push  <= 2'd0;
      candidate_push <= 2'd0;
    end else if (step) begin
      system_on      <= system_on_next;
      main_on        <= main_on_next;
      high_on        <= high_on_next;
      position_on    <= position_on_next;
      left_turn      <= left_turn_next;
      right_turn     <= right_turn_next;
      blink_phase    <= blink_phase_next;
      kill_timer     <= kill_timer_next;
      stable_count   <= stable_count_next;
      accepted_push  <= accepted_push_next;
      candidate_push <= candidate_push_next;
    end
  end

endmodule

`default_nettype wire
